// ===== sv/dfl_pkg.sv =====
// Shared constants, state codes and types for the decimal float literal lexer.
`default_nettype none

package dfl_pkg;

    localparam int unsigned EXP_LIMIT = 1023;

    localparam int SIG_W   = 63;
    localparam int FRAC_W  = 11;
    localparam int EXP_W   = 11;
    localparam int SCALE_W = 12;

    localparam logic [SIG_W-1:0]  SIG_MAX  = {SIG_W{1'b1}};
    localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_UNDER = 8'h5f;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_LO_E  = 8'h65;
    localparam logic [7:0] CHAR_UP_E  = 8'h45;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LO_D  = 8'h64;
    localparam logic [7:0] CHAR_UP_D  = 8'h44;

    localparam logic [3:0] ST_START    = 4'd0;
    localparam logic [3:0] ST_INT      = 4'd1;
    localparam logic [3:0] ST_DOT_LEAD = 4'd2;
    localparam logic [3:0] ST_POINT    = 4'd3;
    localparam logic [3:0] ST_FRAC     = 4'd4;
    localparam logic [3:0] ST_EXP_MARK = 4'd5;
    localparam logic [3:0] ST_EXP_SIGN = 4'd6;
    localparam logic [3:0] ST_EXP_DIG  = 4'd7;
    localparam logic [3:0] ST_SUFFIX   = 4'd8;

    localparam logic [1:0] PH_NONE  = 2'd0;
    localparam logic [1:0] PH_DIGIT = 2'd1;
    localparam logic [1:0] PH_UNDER = 2'd2;

    localparam logic [1:0] SFX_NONE = 2'd0;
    localparam logic [1:0] SFX_F    = 2'd1;
    localparam logic [1:0] SFX_D    = 2'd2;

    typedef struct packed {
        logic       is_digit;
        logic [3:0] digit;
        logic       is_dot;
        logic       is_under;
        logic       is_e;
        logic       is_sign;
        logic       is_minus;
        logic [1:0] suffix;
    } char_class_t;

    typedef struct packed {
        logic                      accepted;
        logic [SIG_W-1:0]          significand;
        logic signed [SCALE_W-1:0] decimal_scale;
        logic [1:0]                suffix_kind;
        logic                      overflow;
    } lex_result_t;

endpackage

`default_nettype wire

// ===== sv/dfl_char_class.sv =====
// Character classifier: decodes one byte into digit, punctuation and suffix flags.
`default_nettype none

module dfl_char_class (
    input  wire logic [7:0]          char_code,
    output dfl_pkg::char_class_t     cls
);
    import dfl_pkg::*;

    logic is_digit;

    assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);

    always_comb
    begin
        cls          = '0;
        cls.is_digit = is_digit;
        cls.digit    = is_digit ? 4'(char_code - CHAR_ZERO) : 4'd0;
        cls.is_dot   = char_code == CHAR_DOT;
        cls.is_under = char_code == CHAR_UNDER;
        cls.is_e     = (char_code == CHAR_LO_E) || (char_code == CHAR_UP_E);
        cls.is_sign  = (char_code == CHAR_PLUS) || (char_code == CHAR_MINUS);
        cls.is_minus = char_code == CHAR_MINUS;
        if ((char_code == CHAR_LO_F) || (char_code == CHAR_UP_F))
        begin
            cls.suffix = SFX_F;
        end
        else if ((char_code == CHAR_LO_D) || (char_code == CHAR_UP_D))
        begin
            cls.suffix = SFX_D;
        end
        else
        begin
            cls.suffix = SFX_NONE;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dfl_lex_core.sv =====
// Lexer state, digit accumulators and end-of-string result formation.
`default_nettype none

module dfl_lex_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic                  last,
    input  dfl_pkg::char_class_t       cls,
    output dfl_pkg::lex_result_t       result
);
    import dfl_pkg::*;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [SIG_W-1:0]  mant_reg, mant_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [EXP_W-1:0]  exp_reg, exp_next;
    logic              neg_reg, neg_next;
    logic [1:0]        sfx_reg, sfx_next;
    logic              dead_reg, dead_next;
    logic              sat_reg, sat_next;

    logic [SIG_W+3:0]  mant_wide;
    logic              mant_sat;
    logic [EXP_W+3:0]  exp_wide;
    logic              exp_sat;

    logic              add_m, add_frac, add_e, take_u, close_run, close_sfx;
    logic [3:0]        close_to;

    logic signed [SCALE_W:0] exp_s, scale_s;
    logic                    acc;

    assign mant_wide = {1'b0, mant_reg, 3'b000} + {3'b000, mant_reg, 1'b0}
                     + {(SIG_W)'(0), cls.digit};
    assign mant_sat  = |mant_wide[SIG_W+3:SIG_W];
    assign exp_wide  = {1'b0, exp_reg, 3'b000} + {3'b000, exp_reg, 1'b0}
                     + {(EXP_W)'(0), cls.digit};
    assign exp_sat   = exp_wide > (EXP_W+4)'(EXP_LIMIT);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        mant_next  = mant_reg;
        frac_next  = frac_reg;
        exp_next   = exp_reg;
        neg_next   = neg_reg;
        sfx_next   = sfx_reg;
        dead_next  = dead_reg;
        sat_next   = sat_reg;
        add_m      = 1'b0;
        add_frac   = 1'b0;
        add_e      = 1'b0;
        take_u     = 1'b0;
        close_run  = 1'b0;
        close_sfx  = 1'b0;
        close_to   = state_reg;

        if (!dead_reg)
        begin
            case (state_reg)
                ST_START:
                begin
                    if (cls.is_digit)
                    begin
                        state_next = ST_INT;
                        add_m      = 1'b1;
                    end
                    else if (cls.is_dot)
                    begin
                        state_next = ST_DOT_LEAD;
                    end
                    else
                    begin
                        dead_next = 1'b1;
                    end
                end
                ST_INT, ST_FRAC:
                begin
                    if (cls.is_digit)
                    begin
                        add_m    = 1'b1;
                        add_frac = state_reg == ST_FRAC;
                    end
                    else if (cls.is_under)
                    begin
                        take_u = 1'b1;
                    end
                    else if (cls.is_dot && (state_reg == ST_INT))
                    begin
                        close_run = 1'b1;
                        close_to  = ST_POINT;
                    end
                    else if (cls.is_e)
                    begin
                        close_run = 1'b1;
                        close_to  = ST_EXP_MARK;
                    end
                    else if (cls.suffix != SFX_NONE)
                    begin
                        close_run = 1'b1;
                        close_sfx = 1'b1;
                        close_to  = ST_SUFFIX;
                    end
                    else
                    begin
                        dead_next = 1'b1;
                    end
                end
                ST_DOT_LEAD:
                begin
                    if (cls.is_digit)
                    begin
                        state_next = ST_FRAC;
                        add_m      = 1'b1;
                        add_frac   = 1'b1;
                    end
                    else
                    begin
                        dead_next = 1'b1;
                    end
                end
                ST_POINT:
                begin
                    if (cls.is_digit)
                    begin
                        state_next = ST_FRAC;
                        add_m      = 1'b1;
                        add_frac   = 1'b1;
                    end
                    else if (cls.is_e)
                    begin
                        state_next = ST_EXP_MARK;
                    end
                    else if (cls.suffix != SFX_NONE)
                    begin
                        state_next = ST_SUFFIX;
                        sfx_next   = cls.suffix;
                    end
                    else
                    begin
                        dead_next = 1'b1;
                    end
                end
                ST_EXP_MARK:
                begin
                    if (cls.is_sign)
                    begin
                        state_next = ST_EXP_SIGN;
                        neg_next   = cls.is_minus;
                    end
                    else if (cls.is_digit)
                    begin
                        state_next = ST_EXP_DIG;
                        add_e      = 1'b1;
                    end
                    else
                    begin
                        dead_next = 1'b1;
                    end
                end
                ST_EXP_SIGN:
                begin
                    if (cls.is_digit)
                    begin
                        state_next = ST_EXP_DIG;
                        add_e      = 1'b1;
                    end
                    else
                    begin
                        dead_next = 1'b1;
                    end
                end
                ST_EXP_DIG:
                begin
                    if (cls.is_digit)
                    begin
                        add_e = 1'b1;
                    end
                    else if (cls.is_under)
                    begin
                        take_u = 1'b1;
                    end
                    else if (cls.suffix != SFX_NONE)
                    begin
                        close_run = 1'b1;
                        close_sfx = 1'b1;
                        close_to  = ST_SUFFIX;
                    end
                    else
                    begin
                        dead_next = 1'b1;
                    end
                end
                default:
                begin
                    dead_next = 1'b1;
                end
            endcase

            if (add_m)
            begin
                phase_next = PH_DIGIT;
                if (mant_sat)
                begin
                    mant_next = SIG_MAX;
                    sat_next  = 1'b1;
                end
                else
                begin
                    mant_next = mant_wide[SIG_W-1:0];
                end
                if (add_frac)
                begin
                    if (frac_reg == FRAC_MAX)
                    begin
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        frac_next = frac_reg + 1'b1;
                    end
                end
            end

            if (add_e)
            begin
                phase_next = PH_DIGIT;
                if (exp_sat)
                begin
                    exp_next = EXP_W'(EXP_LIMIT);
                    sat_next = 1'b1;
                end
                else
                begin
                    exp_next = exp_wide[EXP_W-1:0];
                end
            end

            if (take_u)
            begin
                if (phase_reg == PH_NONE)
                begin
                    dead_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_UNDER;
                end
            end

            if (close_run)
            begin
                if (phase_reg != PH_DIGIT)
                begin
                    dead_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_NONE;
                    state_next = close_to;
                    if (close_sfx)
                    begin
                        sfx_next = cls.suffix;
                    end
                end
            end
        end
    end

    assign acc = !dead_next &&
                 ((state_next == ST_POINT) || (state_next == ST_SUFFIX) ||
                  (((state_next == ST_FRAC) || (state_next == ST_EXP_DIG)) &&
                   (phase_next == PH_DIGIT)));

    assign exp_s   = neg_next ? -$signed({2'b00, exp_next}) : $signed({2'b00, exp_next});
    assign scale_s = exp_s - $signed({2'b00, frac_next});

    always_comb
    begin
        result = '0;
        if (acc)
        begin
            result.accepted    = 1'b1;
            result.significand = mant_next;
            result.suffix_kind = sfx_next;
            result.overflow    = sat_next;
            if (scale_s > $signed((SCALE_W+1)'(2047)))
            begin
                result.decimal_scale = SCALE_W'(2047);
                result.overflow      = 1'b1;
            end
            else if (scale_s < -$signed((SCALE_W+1)'(2048)))
            begin
                result.decimal_scale = {1'b1, (SCALE_W-1)'(0)};
                result.overflow      = 1'b1;
            end
            else
            begin
                result.decimal_scale = scale_s[SCALE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            phase_reg <= PH_NONE;
            mant_reg  <= '0;
            frac_reg  <= '0;
            exp_reg   <= '0;
            neg_reg   <= 1'b0;
            sfx_reg   <= SFX_NONE;
            dead_reg  <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                state_reg <= ST_START;
                phase_reg <= PH_NONE;
                mant_reg  <= '0;
                frac_reg  <= '0;
                exp_reg   <= '0;
                neg_reg   <= 1'b0;
                sfx_reg   <= SFX_NONE;
                dead_reg  <= 1'b0;
                sat_reg   <= 1'b0;
            end
            else
            begin
                state_reg <= state_next;
                phase_reg <= phase_next;
                mant_reg  <= mant_next;
                frac_reg  <= frac_next;
                exp_reg   <= exp_next;
                neg_reg   <= neg_next;
                sfx_reg   <= sfx_next;
                dead_reg  <= dead_next;
                sat_reg   <= sat_next;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) phase_reg != 2'd3)
        else $error("digit run phase took an unused code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (exp_reg <= EXP_W'(EXP_LIMIT)))
        else $error("exponent accumulator above its limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg <= ST_SUFFIX))
        else $error("lexer state took an unused code");

endmodule

`default_nettype wire

// ===== sv/decimal_float_literal_lexer.sv =====
// Top level: input beat register, lexer core and result register.
//
//  channel | signals                                           | dir
//  --------+---------------------------------------------------+-----
//  in      | in_valid, in_ready, char_code, last_char          | in
//  out     | out_valid, out_ready, accepted, significand,      | out
//          | decimal_scale, suffix_kind, overflow              |
//
// One beat per cycle while no held result stalls a last beat: each character
// waits in the input register, where the lexer state is updated, and a last
// character loads the result register at the same edge, setting out_valid.
// Reset returns the lexer to the start state and empties both registers.
// A held result stalls the input only when the next beat is itself a last beat.
`default_nettype none

module decimal_float_literal_lexer (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [7:0]                           char_code,
    input  wire logic                                 last_char,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      accepted,
    output logic [dfl_pkg::SIG_W-1:0]                 significand,
    output logic signed [dfl_pkg::SCALE_W-1:0]        decimal_scale,
    output logic [1:0]                                suffix_kind,
    output logic                                      overflow
);
    import dfl_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   char_reg;
    logic         last_reg;
    logic         out_valid_reg, out_valid_next;
    lex_result_t  result_reg;
    lex_result_t  result_comb;
    char_class_t  cls;
    logic         consume;

    assign consume  = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || consume;

    dfl_char_class u_class (
        .char_code (char_reg),
        .cls       (cls)
    );

    dfl_lex_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (consume),
        .last   (last_reg),
        .cls    (cls),
        .result (result_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
            last_reg <= last_char;
        end
    end

    always_comb
    begin
        if (consume && last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && last_reg)
        begin
            result_reg <= result_comb;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = result_reg.accepted;
    assign significand   = result_reg.significand;
    assign decimal_scale = result_reg.decimal_scale;
    assign suffix_kind   = result_reg.suffix_kind;
    assign overflow      = result_reg.overflow;

    assert property (@(posedge clk) disable iff (!rst_n)
        consume && last_reg |-> !out_valid_reg || out_ready)
        else $error("result register overwritten while held");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !accepted |->
            significand == '0 && decimal_scale == '0 && suffix_kind == SFX_NONE && !overflow)
        else $error("rejected string carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> suffix_kind != 2'd3)
        else $error("suffix kind out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !last_reg |-> in_ready)
        else $error("input stalled on a non-final beat");

endmodule

`default_nettype wire
